// ----- rtl/sba_pkg.sv -----
// Shared constants, types and helpers for the skyline block allocator.
package sba_pkg;

  // Largest atlas side supported; sets the column store depth.
  localparam int MAX_SIZE = 256;
  localparam int AW       = $clog2(MAX_SIZE);
  localparam int HT_W     = $clog2(MAX_SIZE + 1);

  // Fixed field widths of the interface.
  localparam int SZ_W    = 9;
  localparam int IN_W    = 9;
  localparam int POS_W   = 8;
  localparam int WW      = IN_W + 1;
  localparam int SUM_W   = ((HT_W > WW) ? HT_W : WW) + 1;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 3;

  // Atlas side after reset, held within the supported range.
  localparam int RST_SIZE = (64 > MAX_SIZE) ? MAX_SIZE : 64;

  // Register index as decoded from the word address bit.
  localparam logic REG_ATLAS_SIZE = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FWD,
    ST_BWD,
    ST_CHECK,
    ST_WRITE,
    ST_DONE
  } sba_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic ld_fwd;
    logic fwd;
    logic ld_bwd;
    logic bwd;
    logic check;
    logic ld_wr;
    logic wr;
    logic out_ld;
  } sba_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic too_wide;
    logic last_proc;
    logic fits;
    logic wr_last;
    logic out_free;
  } sba_stat_t;

  function automatic logic [HT_W-1:0] ht_max(input logic [HT_W-1:0] a,
                                             input logic [HT_W-1:0] b);
    ht_max = (a > b) ? a : b;
  endfunction

endpackage

// ----- rtl/sba_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module sba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/sba_ctrl.sv -----
// Controller state machine sequencing the scan passes and the column update.
module sba_ctrl import sba_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  sba_stat_t st,
  output sba_cmd_t  cmd
);

  sba_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (st.too_wide) begin
            state_nxt = ST_DONE;
          end else begin
            cmd.ld_fwd = 1'b1;
            state_nxt  = ST_FWD;
          end
        end
      end
      ST_FWD: begin
        cmd.fwd = 1'b1;
        if (st.last_proc) begin
          cmd.ld_bwd = 1'b1;
          state_nxt  = ST_BWD;
        end
      end
      ST_BWD: begin
        cmd.bwd = 1'b1;
        if (st.last_proc) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        if (st.fits) begin
          cmd.ld_wr = 1'b1;
          state_nxt = ST_WRITE;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_WRITE: begin
        cmd.wr = 1'b1;
        if (st.wr_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (st.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/sba_dp.sv -----
// Datapath: column heights, block prefix maxima, window search and result register.
module sba_dp import sba_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [SZ_W-1:0]  atlas_size,
  input  logic             clr_heights,
  input  logic [IN_W-1:0]  in_block_width,
  input  logic [IN_W-1:0]  in_block_height,
  input  sba_cmd_t         cmd,
  output sba_stat_t        st,
  input  logic             out_stall,
  output logic             out_valid,
  output logic             out_failed,
  output logic [POS_W-1:0] out_pos_x,
  output logic [POS_W-1:0] out_pos_y
);

  logic [WW-1:0]       w_r, w_nxt, h_r, h_nxt;
  logic [AW-1:0]       k_r, k_nxt, kd_r, kd_nxt;
  logic                run_r, run_nxt, act_r, act_nxt;
  logic [AW-1:0]       cnt_r, cnt_nxt;
  logic [HT_W-1:0]     pmax_r, pmax_nxt, smax_r, smax_nxt;
  logic                newblk_r, newblk_nxt;
  logic [HT_W-1:0]     best_r, best_nxt;
  logic [AW-1:0]       px_r, px_nxt;
  logic                found_r, found_nxt, fail_r, fail_nxt;
  logic [AW-1:0]       wa_r, wa_nxt, wcnt_r, wcnt_nxt;
  logic [MAX_SIZE-1:0] vld_r, vld_nxt;
  logic                rvld_r, rvld_nxt;
  logic                out_valid_r, out_valid_nxt, out_failed_r, out_failed_nxt;
  logic [POS_W-1:0]    out_pos_x_r, out_pos_x_nxt, out_pos_y_r, out_pos_y_nxt;

  logic [HT_W-1:0]  ht_raw, ht, p_rd, pval, sval, wmax;
  logic [WW-1:0]    w_in, w_m1;
  logic [SZ_W-1:0]  size_m1;
  logic [SUM_W-1:0] size_ext, new_top;
  logic [AW-1:0]    p_raddr;
  logic             cnt_end, is_start, take, fits, k_last;

  // Column heights; entries never written since the last clear read as zero.
  sba_ram #(.WIDTH(HT_W), .DEPTH(MAX_SIZE)) u_heights (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (wa_r),
    .wdata (HT_W'(new_top)),
    .raddr (k_r),
    .rdata (ht_raw)
  );

  // Prefix maxima within blocks of the request width.
  sba_ram #(.WIDTH(HT_W), .DEPTH(MAX_SIZE)) u_prefix (
    .clk   (clk),
    .we    (cmd.fwd && act_r),
    .waddr (kd_r),
    .wdata (pval),
    .raddr (p_raddr),
    .rdata (p_rd)
  );

  // Window maxima: suffix maximum at the start combined with prefix maximum at the end.
  always_comb begin
    ht       = rvld_r ? ht_raw : '0;
    w_in     = WW'(in_block_width) + WW'(1);
    w_m1     = w_r - WW'(1);
    size_m1  = atlas_size - SZ_W'(1);
    size_ext = SUM_W'(atlas_size);
    cnt_end  = (WW'(cnt_r) == w_m1);
    k_last   = (SZ_W'(k_r) == size_m1);
    p_raddr  = AW'(SUM_W'(k_r) + SUM_W'(w_r) - SUM_W'(1));
    pval     = (cnt_r == '0) ? ht : ht_max(pmax_r, ht);
    sval     = newblk_r ? ht : ht_max(smax_r, ht);
    wmax     = ht_max(sval, p_rd);
    is_start = (SUM_W'(kd_r) + SUM_W'(w_r)) <= size_ext;
    take     = cmd.bwd && act_r && is_start && (wmax <= best_r) &&
               (SUM_W'(wmax) < size_ext);
    new_top  = SUM_W'(best_r) + SUM_W'(h_r);
    fits     = found_r && (new_top <= size_ext);
  end

  // Status to the controller.
  always_comb begin
    st.too_wide  = w_in > WW'(atlas_size);
    st.last_proc = act_r && !run_r;
    st.fits      = fits;
    st.wr_last   = (WW'(wcnt_r) == w_m1);
    st.out_free  = !out_valid_r || !out_stall;
  end

  // Next values of the datapath registers.
  always_comb begin
    w_nxt          = w_r;
    h_nxt          = h_r;
    k_nxt          = k_r;
    kd_nxt         = k_r;
    run_nxt        = run_r;
    act_nxt        = 1'b0;
    cnt_nxt        = cnt_r;
    pmax_nxt       = pmax_r;
    smax_nxt       = smax_r;
    newblk_nxt     = newblk_r;
    best_nxt       = best_r;
    px_nxt         = px_r;
    found_nxt      = found_r;
    fail_nxt       = fail_r;
    wa_nxt         = wa_r;
    wcnt_nxt       = wcnt_r;
    vld_nxt        = vld_r;
    rvld_nxt       = vld_r[k_r];
    out_valid_nxt  = out_valid_r && out_stall;
    out_failed_nxt = out_failed_r;
    out_pos_x_nxt  = out_pos_x_r;
    out_pos_y_nxt  = out_pos_y_r;

    // Latch the request with its margin added.
    if (cmd.accept) begin
      w_nxt    = w_in;
      h_nxt    = WW'(in_block_height) + WW'(1);
      fail_nxt = st.too_wide;
    end

    // Read issue: upwards on the forward pass, downwards on the backward pass.
    if ((cmd.fwd || cmd.bwd) && run_r) begin
      act_nxt = 1'b1;
      if (cmd.fwd) begin
        if (k_last) begin
          run_nxt = 1'b0;
        end else begin
          k_nxt = k_r + AW'(1);
        end
      end else begin
        if (k_r == '0) begin
          run_nxt = 1'b0;
        end else begin
          k_nxt = k_r - AW'(1);
        end
      end
    end

    // Forward pass: running maximum restarted at each block start.
    if (cmd.fwd && act_r) begin
      pmax_nxt = pval;
      cnt_nxt  = cnt_end ? '0 : cnt_r + AW'(1);
    end

    // Backward pass: suffix maximum and the leftmost lowest window.
    if (cmd.bwd && act_r) begin
      smax_nxt   = sval;
      newblk_nxt = (cnt_r == '0);
      cnt_nxt    = (cnt_r == '0) ? AW'(w_m1) : cnt_r - AW'(1);
      if (take) begin
        best_nxt  = wmax;
        px_nxt    = kd_r;
        found_nxt = 1'b1;
      end
    end

    if (cmd.ld_fwd) begin
      k_nxt   = '0;
      run_nxt = 1'b1;
      cnt_nxt = '0;
    end

    // The block offset of the top column carries over into the backward pass.
    if (cmd.ld_bwd) begin
      k_nxt      = AW'(size_m1);
      run_nxt    = 1'b1;
      cnt_nxt    = cnt_r;
      newblk_nxt = 1'b1;
      best_nxt   = HT_W'(atlas_size);
      found_nxt  = 1'b0;
    end

    if (cmd.check) begin
      fail_nxt = !fits;
    end

    // Raise the chosen columns one per cycle.
    if (cmd.ld_wr) begin
      wa_nxt   = px_r;
      wcnt_nxt = '0;
    end
    if (cmd.wr) begin
      wa_nxt       = wa_r + AW'(1);
      wcnt_nxt     = wcnt_r + AW'(1);
      vld_nxt[wa_r] = 1'b1;
    end
    if (clr_heights) begin
      vld_nxt = '0;
    end

    // Result register.
    if (cmd.out_ld) begin
      out_valid_nxt  = 1'b1;
      out_failed_nxt = fail_r;
      out_pos_x_nxt  = fail_r ? '0 : POS_W'(px_r);
      out_pos_y_nxt  = fail_r ? '0 : POS_W'(best_r);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= 1'b0;
      act_r       <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      run_r       <= run_nxt;
      act_r       <= act_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    w_r          <= w_nxt;
    h_r          <= h_nxt;
    k_r          <= k_nxt;
    kd_r         <= kd_nxt;
    cnt_r        <= cnt_nxt;
    pmax_r       <= pmax_nxt;
    smax_r       <= smax_nxt;
    newblk_r     <= newblk_nxt;
    best_r       <= best_nxt;
    px_r         <= px_nxt;
    found_r      <= found_nxt;
    fail_r       <= fail_nxt;
    wa_r         <= wa_nxt;
    wcnt_r       <= wcnt_nxt;
    rvld_r       <= rvld_nxt;
    out_failed_r <= out_failed_nxt;
    out_pos_x_r  <= out_pos_x_nxt;
    out_pos_y_r  <= out_pos_y_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_failed = out_failed_r;
  assign out_pos_x  = out_pos_x_r;
  assign out_pos_y  = out_pos_y_r;

endmodule

// ----- rtl/skyline_block_allocator_core.sv -----
// Top level of the skyline block allocator: register port, controller and datapath.
//
//  channel  direction  handshake          payload
//  in       input      in_valid/in_stall  in_block_width, in_block_height
//  out      output     out_valid/out_stall out_failed, out_pos_x, out_pos_y
//  cfg      input      psel/penable       paddr, pwrite, pwdata, prdata, pready
//
// A request makes one forward and one backward sweep over the column store, reading one
// column per cycle, then w writes (w = block_width + 1).
// A request wider than the atlas skips the sweeps and goes straight to its result.
// Reset and every write to atlas_size clear all column heights at once.
// A finished beat waits in the output register; the next request is taken meanwhile.
// out_stall holds the result and a request done behind it; input stalls while one runs.
module skyline_block_allocator_core import sba_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [IN_W-1:0]    in_block_width,
  input  logic [IN_W-1:0]    in_block_height,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_failed,
  output logic [POS_W-1:0]   out_pos_x,
  output logic [POS_W-1:0]   out_pos_y,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  logic [SZ_W-1:0] size_r, size_nxt;
  logic [SZ_W-1:0] wval;
  logic            size_wr;
  sba_cmd_t        cmd;
  sba_stat_t       st;

  // Register port: atlas size, saturated to the supported maximum.
  always_comb begin
    wval     = pwdata[SZ_W-1:0];
    size_wr  = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_ATLAS_SIZE);
    size_nxt = size_r;
    if (size_wr) begin
      size_nxt = (32'(wval) > 32'(MAX_SIZE)) ? SZ_W'(MAX_SIZE) : wval;
    end
    prdata = (paddr[PADDR_W-1] == REG_ATLAS_SIZE) ? DATA_W'(size_r) : '0;
    pready = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SZ_W'(RST_SIZE);
    end else begin
      size_r <= size_nxt;
    end
  end

  sba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  sba_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .atlas_size      (size_r),
    .clr_heights     (size_wr),
    .in_block_width  (in_block_width),
    .in_block_height (in_block_height),
    .cmd             (cmd),
    .st              (st),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_failed      (out_failed),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y)
  );

endmodule

// ----- verif/skyline_block_allocator_core_tb.sv -----
// Self-checking testbench for the skyline block allocator core.
`timescale 1ns / 100ps

module skyline_block_allocator_core_tb import sba_pkg::*; ();

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int IDLE_PCT    = 22;
  localparam int N_PHASES    = 11;

  // Register addresses: the atlas side, and a spare word that decodes to nothing.
  localparam logic [PADDR_W-1:0] ADDR_ATLAS_SIZE = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_SPARE      = 3'd4;

  typedef enum logic {STEP_REQ, STEP_CFG} step_kind_t;

  typedef struct packed {
    logic             failed;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
  } placement_t;

  typedef struct {
    step_kind_t         kind;
    logic [PADDR_W-1:0] addr;
    logic [DATA_W-1:0]  data;
    logic [IN_W-1:0]    bw;
    logic [IN_W-1:0]    bh;
    bit                 typed;
    placement_t         want;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [IN_W-1:0]    in_block_width = '0;
  logic [IN_W-1:0]    in_block_height = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_failed;
  logic [POS_W-1:0]   out_pos_x;
  logic [POS_W-1:0]   out_pos_y;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  // Predictor state: atlas side and the skyline of column heights.
  logic [8:0]  atlas_side;
  logic [8:0]  skyline [MAX_SIZE];
  placement_t  placement_q [$];
  plan_row_t   plan [$];
  int          errors = 0;
  int          cycles = 0;
  bit          steady = 1'b0;

  int phase_size [N_PHASES] = '{64, 16, 256, 3, 32, 1, 100, 8, 200, 48, 0};
  int phase_len  [N_PHASES] = '{90, 80, 12, 40, 80, 20, 40, 60, 10, 60, 60};

  skyline_block_allocator_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_block_width  (in_block_width),
    .in_block_height (in_block_height),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_failed      (out_failed),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Set the atlas side as the register stores it, and flatten the skyline.
  task automatic set_atlas_side(input logic [DATA_W-1:0] value);
    logic [8:0] v;
    v = value[8:0];
    if (32'(v) > MAX_SIZE) v = 9'(MAX_SIZE);
    atlas_side = v;
    for (int c = 0; c < MAX_SIZE; c++) skyline[c] = '0;
  endtask

  // Place one block on the skyline: leftmost window with the strictly lowest top.
  function automatic placement_t place_block(input logic [IN_W-1:0] bw,
                                             input logic [IN_W-1:0] bh);
    int unsigned w, h, side, best, px, top, c;
    bit          found, clear;
    placement_t  r;
    w     = 32'(bw) + 1;
    h     = 32'(bh) + 1;
    side  = 32'(atlas_side);
    best  = side;
    px    = 0;
    found = 1'b0;
    r        = '0;
    r.failed = 1'b1;
    if (w <= side) begin
      for (int i = 0; i + w <= side; i++) begin
        top   = 0;
        clear = 1'b1;
        for (int j = 0; j < w; j++) begin
          c = 32'(skyline[i + j]);
          if (c >= best) begin
            clear = 1'b0;
            break;
          end
          if (c > top) top = c;
        end
        if (clear) begin
          best  = top;
          px    = i;
          found = 1'b1;
        end
      end
      if (found && best + h <= side) begin
        for (int j = 0; j < w; j++) skyline[px + j] = 9'(best + h);
        r.failed = 1'b0;
        r.pos_x  = px[POS_W-1:0];
        r.pos_y  = best[POS_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic void add_req(input int bw, input int bh);
    plan.push_back('{STEP_REQ, '0, '0, IN_W'(bw), IN_W'(bh), 1'b0, '0});
  endfunction

  function automatic void add_typed(input int bw, input int bh, input bit failed,
                                    input int px, input int py);
    placement_t p;
    p = '{failed, POS_W'(px), POS_W'(py)};
    plan.push_back('{STEP_REQ, '0, '0, IN_W'(bw), IN_W'(bh), 1'b1, p});
  endfunction

  function automatic void add_cfg(input logic [PADDR_W-1:0] addr,
                                  input logic [DATA_W-1:0] data);
    plan.push_back('{STEP_CFG, addr, data, '0, '0, 1'b0, '0});
  endfunction

  // Offer one request beat, with random idle cycles ahead of it.
  task automatic send_block(input logic [IN_W-1:0] bw, input logic [IN_W-1:0] bh,
                            input bit typed, input placement_t want);
    bit         taken;
    placement_t pred;
    if (!steady) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid        <= 1'b1;
    in_block_width  <= bw;
    in_block_height <= bh;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    pred = place_block(bw, bh);
    placement_q.push_back(typed ? want : pred);
  endtask

  // Hold the input back until every outstanding placement has been seen.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (placement_q.size() != 0);
  endtask

  // One APB transfer: setup cycle, then access until pready.
  task automatic apb_transfer(input bit wr, input logic [PADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
    bit done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      done  = pready;
      rdata = prdata;
      @(posedge clk);
    end while (!done);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Write a register, then read the atlas side back.
  task automatic program_reg(input logic [PADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] rd;
    apb_transfer(1'b1, addr, value, rd);
    if (addr == ADDR_ATLAS_SIZE) set_atlas_side(value);
    apb_transfer(1'b0, ADDR_ATLAS_SIZE, '0, rd);
    if (rd !== DATA_W'(atlas_side)) begin
      $error("prdata: expected %0d, actual %0d", atlas_side, rd);
      errors++;
    end
  endtask

  function automatic logic [IN_W-1:0] pick(input int unsigned lim);
    if (lim > MAX_SIZE) lim = MAX_SIZE;
    return IN_W'($urandom_range(0, lim));
  endfunction

  // The receiver stalls at random, except during the steady phase.
  always @(posedge clk) begin
    out_stall <= rst_n && !steady && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // A result beat is taken at the next rising edge; compare it with the oldest placement.
  always @(negedge clk) begin
    placement_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (placement_q.size() == 0) begin
        $error("unexpected result beat: failed %0d pos_x %0d pos_y %0d",
               out_failed, out_pos_x, out_pos_y);
        errors++;
      end else begin
        want = placement_q.pop_front();
        if (out_failed !== want.failed) begin
          $error("failed: expected %0d, actual %0d", want.failed, out_failed);
          errors++;
        end
        if (out_pos_x !== want.pos_x) begin
          $error("pos_x: expected %0d, actual %0d", want.pos_x, out_pos_x);
          errors++;
        end
        if (out_pos_y !== want.pos_y) begin
          $error("pos_y: expected %0d, actual %0d", want.pos_y, out_pos_y);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned side, lim_w, lim_h, mode;
    logic [IN_W-1:0] bw, bh;

    set_atlas_side(64);

    // Directed rows, starting from the reset side of 64 and a flat skyline.
    add_typed(0, 0, 1'b0, 0, 0);
    add_typed(0, 0, 1'b0, 1, 0);
    add_typed(63, 0, 1'b0, 0, 1);      // full-width window over the two bumps
    add_typed(64, 0, 1'b1, 0, 0);      // one column wider than the atlas
    add_typed(256, 256, 1'b1, 0, 0);   // both fields at 256, beyond the atlas
    add_typed(0, 62, 1'b1, 0, 0);      // one row too tall
    add_typed(0, 61, 1'b0, 0, 2);      // reaches the top exactly
    add_typed(62, 61, 1'b0, 1, 2);     // fills the rest of the atlas
    add_typed(0, 0, 1'b1, 0, 0);       // no free window left
    add_cfg(ADDR_SPARE, 5);            // ignored: skyline must stay full
    add_typed(0, 0, 1'b1, 0, 0);
    add_cfg(ADDR_ATLAS_SIZE, 0);       // empty atlas: everything fails
    add_typed(0, 0, 1'b1, 0, 0);
    add_cfg(ADDR_ATLAS_SIZE, 1);
    add_typed(0, 0, 1'b0, 0, 0);
    add_typed(0, 0, 1'b1, 0, 0);
    add_cfg(ADDR_ATLAS_SIZE, 300);     // saturates to the largest side
    add_typed(255, 255, 1'b0, 0, 0);
    add_typed(0, 0, 1'b1, 0, 0);
    add_typed(256, 0, 1'b1, 0, 0);
    add_cfg(ADDR_ATLAS_SIZE, 32'hFFFF_FE40);  // upper bits dropped: side 64
    add_req(5, 7);
    add_typed(255, 1, 1'b1, 0, 0);
    add_req(0, 256);
    add_typed(170, 85, 1'b1, 0, 0);
    add_req(2, 9);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[k]) begin
      if (plan[k].kind == STEP_CFG) begin
        wait_drained();
        program_reg(plan[k].addr, plan[k].data);
      end else begin
        send_block(plan[k].bw, plan[k].bh, plan[k].typed, plan[k].want);
      end
    end

    // Random phases, each on a freshly cleared atlas of its own side.
    phase_size[N_PHASES-1] = $urandom_range(2, 128);
    for (int p = 0; p < N_PHASES; p++) begin
      wait_drained();
      program_reg(ADDR_ATLAS_SIZE, phase_size[p]);
      steady = (phase_size[p] == 16);
      side   = 32'(atlas_side);
      for (int n = 0; n < phase_len[p]; n++) begin
        if (n == phase_len[p] / 2 || $urandom_range(0, 49) == 0) wait_drained();
        mode = $urandom_range(0, 99);
        if (mode < 70) begin
          lim_w = side / 4;
          lim_h = side / 4;
        end else if (mode < 85) begin
          lim_w = side - 1;
          lim_h = side - 1;
        end else begin
          lim_w = MAX_SIZE;
          lim_h = MAX_SIZE;
        end
        bw = pick(lim_w);
        bh = pick(lim_h);
        send_block(bw, bh, 1'b0, '0);
      end
      steady = 1'b0;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (placement_q.size() != 0) begin
      $error("%0d placements never arrived", placement_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- skyline_block_allocator_core.f -----
rtl/sba_pkg.sv
rtl/sba_ram.sv
rtl/sba_ctrl.sv
rtl/sba_dp.sv
rtl/skyline_block_allocator_core.sv
verif/skyline_block_allocator_core_tb.sv
